FILE: sv/bpcs_pkg.sv
`default_nettype none

package bpcs_pkg;

   localparam int MAX_WIDTH     = 256;
   localparam int MAX_HEIGHT    = 256;
   localparam int FRACTION_BITS = 16;

   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
   localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int NUM_BANKS  = 4;
   localparam int BANK_SEL_W = 2;
   localparam int BANK_BITS  = ADDR_BITS - BANK_SEL_W;
   localparam int BANK_DEPTH = MEM_DEPTH / NUM_BANKS;

   localparam int CH_W     = 16;
   localparam int NUM_CH   = 3;
   localparam int PIX_W    = CH_W * NUM_CH;
   localparam int COORD_W  = 32;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int SCALE_W  = 32;
   localparam int POS_W    = COORD_W + SCALE_W;
   localparam int DIM_W    = 9;
   localparam int ONE_FIX  = 1 << FRACTION_BITS;
   localparam int BLEND_W  = CH_W + FRACTION_BITS + 1;

   localparam int REQ_DATA_W = 128;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int KIND_BIT = 0;
   localparam int INCL_BIT = 1;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_X        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_Y        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd5;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;

   // (a * (1 - f) + b * f) >> F, truncating
   function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] a,
                                             input logic [CH_W-1:0] b,
                                             input logic [FRACTION_BITS-1:0] f);
      logic [BLEND_W-1:0] wa;
      logic [BLEND_W-1:0] s;
      wa = BLEND_W'(ONE_FIX) - BLEND_W'(f);
      s  = BLEND_W'(a) * wa + BLEND_W'(b) * BLEND_W'(f);
      return s[FRACTION_BITS +: CH_W];
   endfunction

endpackage

`default_nettype wire

FILE: sv/bilinear_point_colour_sampler_top.sv
`default_nettype none

// Bilinear point colour sampler.
// Requests arrive on req_*: kind 0 stores one 48-bit RGB pixel at pixel_index
// (row * 256 + column), kind 1 samples the point (point_x, point_y). The point
// maps to column (x - min_x) * scale_x and row (max_y - y) * scale_y, clamped
// to the image, and the four neighbours are blended along y, then along x.
// Results leave on rsp_*; excluded points and pixel writes give none.
// Registers are written on csr_* (always ready); the user must write them only
// while no request is in flight; the block does not enforce this. Throughput: one
// request per cycle unless the output stalls, writes and samples mixed freely.
// The pixel store is four banks (row parity by column parity) of 16384 x 48 bits,
// so the four neighbours of a sample are read together; a write lands in the same
// stage that reads, so a sample always sees the writes requested before it.
// Reset clears the pipeline valid bits and the registers to their defaults;
// pixel contents are undefined until written and get no clearing pass.
// When rsp_tready is low the output holds; stages behind it keep filling
// bubbles, and req_tready drops only once every stage holds an item.
module bilinear_point_colour_sampler_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // pixel_index, pixel_red, pixel_green, pixel_blue, point_x, point_y
   input  wire logic [bpcs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind, included
   input  wire logic [bpcs_pkg::REQ_USER_W-1:0]    req_tuser,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // colour_red, colour_green, colour_blue
   output      logic [bpcs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // edge_clamped
   output      logic [bpcs_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [bpcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bpcs_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int F  = bpcs_pkg::FRACTION_BITS;
   localparam int CB = bpcs_pkg::COL_BITS;
   localparam int RB = bpcs_pkg::ROW_BITS;

   logic [bpcs_pkg::COORD_W-1:0] min_x_ff, max_y_ff;
   logic [bpcs_pkg::SCALE_W-1:0] scale_x_ff, scale_y_ff;
   logic [bpcs_pkg::DIM_W-1:0]   img_w_ff, img_h_ff;

   logic en1, en2, en3, en4, en5, en6;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic v1_in, v4_in;

   logic                                wr1_ff, wr2_ff, wr3_ff;
   logic [15:0]                         idx1_ff, idx2_ff, idx3_ff;
   logic [bpcs_pkg::PIX_W-1:0]          pix1_ff, pix2_ff, pix3_ff;
   logic signed [bpcs_pkg::DIFF_W-1:0]  dx1_in, dy1_in, dx1_ff, dy1_ff;
   logic signed [bpcs_pkg::DIFF_W-1:0]  req_x, req_y, min_x_s, max_y_s;

   logic                        negx2_ff, negy2_ff;
   logic [bpcs_pkg::POS_W-1:0]  prodx2_in, prody2_in, prodx2_ff, prody2_ff;

   logic [CB:0]                 lim_w;
   logic [RB:0]                 lim_h;
   logic [CB-1:0]               max_col;
   logic [RB-1:0]               max_row;
   logic [bpcs_pkg::POS_W-1:0]  top_x, top_y;
   logic [CB-1:0]               c0_3_in, c0_3_ff;
   logic [RB-1:0]               r0_3_in, r0_3_ff;
   logic [F-1:0]                fx3_in, fy3_in, fx3_ff, fy3_ff;
   logic                        clx3, cly3, clamp3_ff;

   logic [RB-2:0]                   row_half [2];
   logic [CB-2:0]                   col_half [2];
   logic [bpcs_pkg::ADDR_BITS-1:0]  wr_full;
   logic [RB-1:0]                   wr_row;
   logic [CB-1:0]                   wr_col;
   logic [bpcs_pkg::BANK_SEL_W-1:0] wr_bank;
   logic [bpcs_pkg::BANK_BITS-1:0]  wr_addr;
   logic                            mem_we;

   logic [bpcs_pkg::PIX_W-1:0]  q4 [bpcs_pkg::NUM_BANKS];
   logic                        rpar4_ff, cpar4_ff, clamp4_ff;
   logic [F-1:0]                fx4_ff, fy4_ff;

   logic [bpcs_pkg::PIX_W-1:0]  p00, p10, p01, p11;
   logic [bpcs_pkg::CH_W-1:0]   lo5_in [bpcs_pkg::NUM_CH];
   logic [bpcs_pkg::CH_W-1:0]   hi5_in [bpcs_pkg::NUM_CH];
   logic [bpcs_pkg::CH_W-1:0]   lo5_ff [bpcs_pkg::NUM_CH];
   logic [bpcs_pkg::CH_W-1:0]   hi5_ff [bpcs_pkg::NUM_CH];
   logic [F-1:0]                fx5_ff;
   logic                        clamp5_ff;

   logic [bpcs_pkg::PIX_W-1:0]  col6_in, col6_ff;
   logic                        clamp6_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff   <= '0;
         max_y_ff   <= '0;
         scale_x_ff <= bpcs_pkg::SCALE_RESET;
         scale_y_ff <= bpcs_pkg::SCALE_RESET;
         img_w_ff   <= bpcs_pkg::DIM_W'(bpcs_pkg::MAX_WIDTH);
         img_h_ff   <= bpcs_pkg::DIM_W'(bpcs_pkg::MAX_HEIGHT);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bpcs_pkg::CSR_MIN_X:        min_x_ff   <= csr_data;
            bpcs_pkg::CSR_MAX_Y:        max_y_ff   <= csr_data;
            bpcs_pkg::CSR_SCALE_X:      scale_x_ff <= csr_data;
            bpcs_pkg::CSR_SCALE_Y:      scale_y_ff <= csr_data;
            bpcs_pkg::CSR_IMAGE_WIDTH:  img_w_ff   <= csr_data[bpcs_pkg::DIM_W-1:0];
            bpcs_pkg::CSR_IMAGE_HEIGHT: img_h_ff   <= csr_data[bpcs_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // stage enables
   assign en6 = !v6_ff || rsp_tready;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   // drop excluded points on entry
   assign v1_in = req_tvalid &&
                  (req_tuser[bpcs_pkg::KIND_BIT] == bpcs_pkg::KIND_WRITE ||
                   req_tuser[bpcs_pkg::INCL_BIT]);
   // writes retire at the memory stage
   assign v4_in = v3_ff && !wr3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= v1_in;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v4_in;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // stage 1: differences
   assign req_x   = {req_tdata[95], req_tdata[95:64]};
   assign req_y   = {req_tdata[127], req_tdata[127:96]};
   assign min_x_s = {min_x_ff[bpcs_pkg::COORD_W-1], min_x_ff};
   assign max_y_s = {max_y_ff[bpcs_pkg::COORD_W-1], max_y_ff};
   assign dx1_in  = req_x - min_x_s;
   assign dy1_in  = max_y_s - req_y;

   always_ff @(posedge clock) begin
      if (en1) begin
         wr1_ff  <= req_tuser[bpcs_pkg::KIND_BIT] == bpcs_pkg::KIND_WRITE;
         idx1_ff <= req_tdata[15:0];
         pix1_ff <= req_tdata[63:16];
         dx1_ff  <= dx1_in;
         dy1_ff  <= dy1_in;
      end
   end

   // stage 2: scale
   assign prodx2_in = bpcs_pkg::POS_W'(dx1_ff[bpcs_pkg::COORD_W-1:0]) *
                      bpcs_pkg::POS_W'(scale_x_ff);
   assign prody2_in = bpcs_pkg::POS_W'(dy1_ff[bpcs_pkg::COORD_W-1:0]) *
                      bpcs_pkg::POS_W'(scale_y_ff);

   always_ff @(posedge clock) begin
      if (en2) begin
         wr2_ff    <= wr1_ff;
         idx2_ff   <= idx1_ff;
         pix2_ff   <= pix1_ff;
         negx2_ff  <= dx1_ff[bpcs_pkg::DIFF_W-1];
         negy2_ff  <= dy1_ff[bpcs_pkg::DIFF_W-1];
         prodx2_ff <= prodx2_in;
         prody2_ff <= prody2_in;
      end
   end

   // stage 3: clamp to image
   always_comb begin
      if (img_w_ff == '0) begin
         lim_w = (CB+1)'(1);
      end else if (32'(img_w_ff) > bpcs_pkg::MAX_WIDTH) begin
         lim_w = (CB+1)'(bpcs_pkg::MAX_WIDTH);
      end else begin
         lim_w = (CB+1)'(img_w_ff);
      end
      if (img_h_ff == '0) begin
         lim_h = (RB+1)'(1);
      end else if (32'(img_h_ff) > bpcs_pkg::MAX_HEIGHT) begin
         lim_h = (RB+1)'(bpcs_pkg::MAX_HEIGHT);
      end else begin
         lim_h = (RB+1)'(img_h_ff);
      end
      max_col = CB'(lim_w - (CB+1)'(1));
      max_row = RB'(lim_h - (RB+1)'(1));
      top_x   = bpcs_pkg::POS_W'({max_col, {F{1'b0}}});
      top_y   = bpcs_pkg::POS_W'({max_row, {F{1'b0}}});
   end

   always_comb begin
      priority if (negx2_ff) begin
         c0_3_in = '0;
         fx3_in  = '0;
         clx3    = 1'b1;
      end else if (prodx2_ff > top_x) begin
         c0_3_in = max_col;
         fx3_in  = '0;
         clx3    = 1'b1;
      end else begin
         c0_3_in = prodx2_ff[F +: CB];
         fx3_in  = prodx2_ff[F-1:0];
         clx3    = 1'b0;
      end
      priority if (negy2_ff) begin
         r0_3_in = '0;
         fy3_in  = '0;
         cly3    = 1'b1;
      end else if (prody2_ff > top_y) begin
         r0_3_in = max_row;
         fy3_in  = '0;
         cly3    = 1'b1;
      end else begin
         r0_3_in = prody2_ff[F +: RB];
         fy3_in  = prody2_ff[F-1:0];
         cly3    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         wr3_ff    <= wr2_ff;
         idx3_ff   <= idx2_ff;
         pix3_ff   <= pix2_ff;
         c0_3_ff   <= c0_3_in;
         r0_3_ff   <= r0_3_in;
         fx3_ff    <= fx3_in;
         fy3_ff    <= fy3_in;
         clamp3_ff <= clx3 || cly3;
      end
   end

   // stage 4: banked pixel store, one write or four reads
   assign row_half[1] = r0_3_ff[RB-1:1];
   assign row_half[0] = r0_3_ff[RB-1:1] + (RB-1)'(r0_3_ff[0]);
   assign col_half[1] = c0_3_ff[CB-1:1];
   assign col_half[0] = c0_3_ff[CB-1:1] + (CB-1)'(c0_3_ff[0]);

   assign wr_full = bpcs_pkg::ADDR_BITS'(idx3_ff);
   assign wr_row  = wr_full[CB +: RB];
   assign wr_col  = wr_full[CB-1:0];
   assign wr_bank = {wr_row[0], wr_col[0]};
   assign wr_addr = {wr_row[RB-1:1], wr_col[CB-1:1]};
   assign mem_we  = en4 && v3_ff && wr3_ff && (32'(idx3_ff) < bpcs_pkg::MEM_DEPTH);

   for (genvar b = 0; b < bpcs_pkg::NUM_BANKS; b++) begin : g_bank
      logic [bpcs_pkg::PIX_W-1:0]     mem [bpcs_pkg::BANK_DEPTH];
      logic [bpcs_pkg::PIX_W-1:0]     rd_ff;
      logic [bpcs_pkg::BANK_BITS-1:0] rd_addr;

      assign rd_addr = {row_half[b / 2], col_half[b % 2]};

      always_ff @(posedge clock) begin
         if (mem_we && wr_bank == bpcs_pkg::BANK_SEL_W'(b)) begin
            mem[wr_addr] <= pix3_ff;
         end
         if (en4) begin
            rd_ff <= mem[rd_addr];
         end
      end

      assign q4[b] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         rpar4_ff  <= r0_3_ff[0];
         cpar4_ff  <= c0_3_ff[0];
         fx4_ff    <= fx3_ff;
         fy4_ff    <= fy3_ff;
         clamp4_ff <= clamp3_ff;
      end
   end

   // stage 5: blend along y; a zero fraction keeps to the floor pixel
   assign p00 = q4[{rpar4_ff, cpar4_ff}];
   assign p10 = (fy4_ff != '0) ? q4[{!rpar4_ff, cpar4_ff}] : p00;
   assign p01 = (fx4_ff != '0) ? q4[{rpar4_ff, !cpar4_ff}] : p00;
   assign p11 = (fy4_ff != '0) ? ((fx4_ff != '0) ? q4[{!rpar4_ff, !cpar4_ff}] : p10)
                               : p01;

   always_comb begin
      for (int k = 0; k < bpcs_pkg::NUM_CH; k++) begin
         lo5_in[k] = bpcs_pkg::blend(p00[k*bpcs_pkg::CH_W +: bpcs_pkg::CH_W],
                                     p10[k*bpcs_pkg::CH_W +: bpcs_pkg::CH_W], fy4_ff);
         hi5_in[k] = bpcs_pkg::blend(p01[k*bpcs_pkg::CH_W +: bpcs_pkg::CH_W],
                                     p11[k*bpcs_pkg::CH_W +: bpcs_pkg::CH_W], fy4_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         lo5_ff    <= lo5_in;
         hi5_ff    <= hi5_in;
         fx5_ff    <= fx4_ff;
         clamp5_ff <= clamp4_ff;
      end
   end

   // stage 6: blend along x, output register
   always_comb begin
      for (int k = 0; k < bpcs_pkg::NUM_CH; k++) begin
         col6_in[k*bpcs_pkg::CH_W +: bpcs_pkg::CH_W] =
            bpcs_pkg::blend(lo5_ff[k], hi5_ff[k], fx5_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         col6_ff   <= col6_in;
         clamp6_ff <= clamp5_ff;
      end
   end

   assign rsp_tvalid   = v6_ff;
   assign rsp_tdata    = col6_ff;
   assign rsp_tuser[0] = clamp6_ff;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !v1_ff && !v2_ff && !v3_ff && !v4_ff && !v5_ff && !v6_ff)
      else $error("pipeline valid bits not cleared by reset");

   a_write_retires: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> !v4_ff)
      else $error("pixel write request reached the blend stages");

   a_drop_excluded: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready &&
       req_tuser[bpcs_pkg::KIND_BIT] == bpcs_pkg::KIND_SAMPLE &&
       !req_tuser[bpcs_pkg::INCL_BIT]) |=> !v1_ff)
      else $error("excluded point entered the pipeline");

   a_negative_clamps: assert property (@(posedge clock) disable iff (reset)
      (en3 && v2_ff && !wr2_ff && negx2_ff) |=>
      (c0_3_ff == '0 && fx3_ff == '0 && clamp3_ff))
      else $error("negative x difference not clamped to column zero");

endmodule

`default_nettype wire
